>>> hw/rtl/icv_pkg.sv
// ----------------------------------------------------------------------------
// Image convolution 3x3 package
// Shared widths, register codes, reset values and pipeline control types.
// ----------------------------------------------------------------------------
package icv_pkg;

	localparam int PIX_BITS    = 8;
	localparam int NUM_CH      = 3;
	localparam int WORD_BITS   = PIX_BITS * NUM_CH;
	localparam int TAPS        = 3;
	localparam int IMG_W_BITS  = 11;
	localparam int IMG_H_BITS  = 13;
	localparam int CHAN_BITS   = 2;
	localparam int KERNEL_BITS = 48;
	localparam int LANE_BITS   = 16;
	localparam int FRAC_BITS   = 12;
	localparam int ROW_BITS    = 16;
	localparam int CFG_IDX_BITS = 3;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int DEF_COEFF_BITS = 16;

	localparam logic [IMG_W_BITS-1:0]  RST_IMAGE_WIDTH   = 11'd1024;
	localparam logic [IMG_H_BITS-1:0]  RST_IMAGE_HEIGHT  = 13'd1024;
	localparam logic [CHAN_BITS-1:0]   RST_CHANNEL_COUNT = 2'd3;
	localparam logic [KERNEL_BITS-1:0] RST_KERNEL_TOP    = 48'h0;
	localparam logic [KERNEL_BITS-1:0] RST_KERNEL_MIDDLE = 48'h0000_1000_0000;
	localparam logic [KERNEL_BITS-1:0] RST_KERNEL_BOTTOM = 48'h0;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_IMAGE_WIDTH   = 3'd0,
		REG_IMAGE_HEIGHT  = 3'd1,
		REG_CHANNEL_COUNT = 3'd2,
		REG_KERNEL_TOP    = 3'd3,
		REG_KERNEL_MIDDLE = 3'd4,
		REG_KERNEL_BOTTOM = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} opcode_t;

	typedef struct packed {
		logic            emit;
		logic            last;
		logic [TAPS-1:0] row_ok;
		logic [TAPS-1:0] col_ok;
	} tap_ctrl_t;

endpackage

>>> hw/rtl/icv_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data (old data on a
// same-address read and write).
// ----------------------------------------------------------------------------
module icv_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

>>> hw/rtl/icv_cell.sv
// ----------------------------------------------------------------------------
// Window column cell
// Holds one 3-pixel column of the window, hands it to its left neighbor on
// each shift, and forms the masked tap products and the column sums.
// ----------------------------------------------------------------------------
module icv_cell import icv_pkg::*; #(
	parameter int COEFF_BITS = DEF_COEFF_BITS
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         col_load,
	input  logic [TAPS-1:0][WORD_BITS-1:0]               col_in,
	input  logic                                         prod_load,
	input  logic [TAPS-1:0]                              row_ok,
	input  logic                                         col_ok,
	input  logic [TAPS-1:0][COEFF_BITS-1:0]              coeff,
	input  logic                                         sum_load,
	output logic [TAPS-1:0][WORD_BITS-1:0]               col_q,
	output logic [NUM_CH-1:0][COEFF_BITS+PIX_BITS+2:0]   col_sum_s4
);

	localparam int PROD_W = COEFF_BITS + PIX_BITS + 1;
	localparam int COL_W  = PROD_W + 2;

	logic signed [PROD_W-1:0] prod_d  [TAPS][NUM_CH];
	logic signed [PROD_W-1:0] prod_s3 [TAPS][NUM_CH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (col_load) begin
			col_q <= col_in;
		end
	end

	always_comb begin
		for (int r = 0; r < TAPS; r++) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				if (row_ok[r] && col_ok) begin
					prod_d[r][ch] = $signed({1'b0, col_q[r][PIX_BITS*ch +: PIX_BITS]})
						* $signed(coeff[r]);
				end else begin
					prod_d[r][ch] = '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (prod_load) begin
			prod_s3 <= prod_d;
		end
		if (sum_load) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				col_sum_s4[ch] <= COL_W'(prod_s3[0][ch]) + COL_W'(prod_s3[1][ch])
					+ COL_W'(prod_s3[2][ch]);
			end
		end
	end

endmodule

>>> hw/rtl/image_convolution_3x3_unit.sv
// ----------------------------------------------------------------------------
// Image convolution 3x3 unit
// A result passes the stage 1, column, product and column-sum registers and
// the output register after the item completing its window, W+1 positions
// after the pixel. Throughput: one item per cycle unless the output stalls;
// RAM read and write once per item, bypass for back-to-back same-column items.
// Reset clears counters, pipeline valids and config registers to defaults;
// line stores are not cleared.
// ----------------------------------------------------------------------------
module image_convolution_3x3_unit import icv_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int COEFF_BITS = DEF_COEFF_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [KERNEL_BITS-1:0]  cfg_wdata,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [WORD_BITS-1:0]    s_axis_tdata,   // sample_a, sample_b, sample_c
	input  logic                    s_axis_tuser,   // opcode
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [WORD_BITS-1:0]    m_axis_tdata,   // result_a, result_b, result_c
	output logic                    m_axis_tlast
);

	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int PROD_W = COEFF_BITS + PIX_BITS + 1;
	localparam int COL_W  = PROD_W + 2;
	localparam int SUM_W  = (PROD_W + 4 > FRAC_BITS + PIX_BITS + 2) ?
		PROD_W + 4 : FRAC_BITS + PIX_BITS + 2;
	localparam int RAM_W  = 2 * WORD_BITS;

	logic [IMG_W_BITS-1:0]  img_w_q;
	logic [IMG_H_BITS-1:0]  img_h_q;
	logic [CHAN_BITS-1:0]   chan_q;
	logic [KERNEL_BITS-1:0] kern_q [TAPS];

	logic [IMG_W_BITS-1:0]  w_eff;
	logic [IMG_H_BITS-1:0]  h_eff;
	logic [CHAN_BITS-1:0]   chans;

	logic [ADDR_W-1:0]      in_col_q;
	logic [ROW_BITS-1:0]    in_row_q;
	logic [ADDR_W-1:0]      out_col_q;
	logic [ROW_BITS-1:0]    out_row_q;

	logic                   accept;
	logic [WORD_BITS-1:0]   acc_pix;
	tap_ctrl_t              acc_ctrl;
	logic                   in_col_wrap;
	logic                   out_col_wrap;

	logic                   rdy1, rdy2, rdy3, rdy4, rdy5;
	logic                   v1_q, v2_q, v3_q, v4_q;
	logic                   adv1, adv2, adv3, adv4;

	logic [ADDR_W-1:0]      addr_s1;
	logic [WORD_BITS-1:0]   pix_s1;
	tap_ctrl_t              ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4;
	logic                   byp_s1;
	logic [RAM_W-1:0]       byp_data_s1;
	logic [RAM_W-1:0]       ram_rdata;
	logic [RAM_W-1:0]       rd_word;
	logic [WORD_BITS-1:0]   top_w, mid_w;

	logic [TAPS-1:0][WORD_BITS-1:0]          col_in  [TAPS];
	logic [TAPS-1:0][WORD_BITS-1:0]          col_q   [TAPS];
	logic [TAPS-1:0][COEFF_BITS-1:0]         coeff_k [TAPS];
	logic [NUM_CH-1:0][COL_W-1:0]            col_sum [TAPS];

	logic signed [SUM_W-1:0] tot [NUM_CH];
	logic [WORD_BITS-1:0]    res_word;
	logic                    out_valid_q;
	logic [WORD_BITS-1:0]    out_data_q;
	logic                    out_last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q   <= RST_IMAGE_WIDTH;
			img_h_q   <= RST_IMAGE_HEIGHT;
			chan_q    <= RST_CHANNEL_COUNT;
			kern_q[0] <= RST_KERNEL_TOP;
			kern_q[1] <= RST_KERNEL_MIDDLE;
			kern_q[2] <= RST_KERNEL_BOTTOM;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:   img_w_q   <= cfg_wdata[IMG_W_BITS-1:0];
				REG_IMAGE_HEIGHT:  img_h_q   <= cfg_wdata[IMG_H_BITS-1:0];
				REG_CHANNEL_COUNT: chan_q    <= cfg_wdata[CHAN_BITS-1:0];
				REG_KERNEL_TOP:    kern_q[0] <= cfg_wdata;
				REG_KERNEL_MIDDLE: kern_q[1] <= cfg_wdata;
				REG_KERNEL_BOTTOM: kern_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (img_w_q == '0) begin
			w_eff = IMG_W_BITS'(1);
		end else if (int'(img_w_q) > MAX_WIDTH) begin
			w_eff = IMG_W_BITS'(MAX_WIDTH);
		end else begin
			w_eff = img_w_q;
		end
		if (img_h_q == '0) begin
			h_eff = IMG_H_BITS'(1);
		end else if (int'(img_h_q) > MAX_HEIGHT) begin
			h_eff = IMG_H_BITS'(MAX_HEIGHT);
		end else begin
			h_eff = img_h_q;
		end
		chans = (chan_q == '0) ? CHAN_BITS'(1) : chan_q;
	end

	// request handshake and pipeline flow
	assign rdy5 = !out_valid_q || m_axis_tready;
	assign rdy4 = !v4_q || rdy5;
	assign rdy3 = !v3_q || rdy4;
	assign rdy2 = !v2_q || rdy3;
	assign rdy1 = !v1_q || rdy2;
	assign adv1 = v1_q && rdy2;
	assign adv2 = v2_q && rdy3;
	assign adv3 = v3_q && rdy4;
	assign adv4 = v4_q && rdy5;
	assign s_axis_tready = rdy1;
	assign accept = s_axis_tvalid && rdy1;

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			if (opcode_t'(s_axis_tuser) == OP_PIXEL && int'(in_row_q) < int'(h_eff)
				&& ch < int'(chans)) begin
				acc_pix[PIX_BITS*ch +: PIX_BITS] = s_axis_tdata[PIX_BITS*ch +: PIX_BITS];
			end else begin
				acc_pix[PIX_BITS*ch +: PIX_BITS] = '0;
			end
		end
		acc_ctrl.emit = (in_row_q >= ROW_BITS'(2))
			|| (in_row_q == ROW_BITS'(1) && in_col_q != '0);
		acc_ctrl.last = (int'(out_row_q) >= int'(h_eff))
			|| (int'(out_row_q) + 1 >= int'(h_eff) && int'(out_col_q) + 1 >= int'(w_eff));
		acc_ctrl.row_ok = {int'(out_row_q) + 1 < int'(h_eff), 1'b1, out_row_q != '0};
		acc_ctrl.col_ok = {int'(out_col_q) + 1 < int'(w_eff), 1'b1, out_col_q != '0};
		in_col_wrap  = int'(in_col_q) + 1 >= int'(w_eff);
		out_col_wrap = int'(out_col_q) + 1 >= int'(w_eff);
	end

	// raster position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			if (acc_ctrl.emit && acc_ctrl.last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_wrap) begin
					in_col_q <= '0;
					if (in_row_q != '1) begin
						in_row_q <= in_row_q + 1'b1;
					end
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
				if (acc_ctrl.emit) begin
					if (out_col_wrap) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + 1'b1;
					end else begin
						out_col_q <= out_col_q + 1'b1;
					end
				end
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			v4_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= s_axis_tvalid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
			if (rdy4) v4_q <= v3_q;
			if (rdy5) out_valid_q <= v4_q && ctrl_s4.emit;
		end
	end

	// stage 1: line store read, bypass on same-column back-to-back items
	assign rd_word = byp_s1 ? byp_data_s1 : ram_rdata;
	assign top_w   = rd_word[RAM_W-1:WORD_BITS];
	assign mid_w   = rd_word[WORD_BITS-1:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1     <= in_col_q;
			pix_s1      <= acc_pix;
			ctrl_s1     <= acc_ctrl;
			byp_s1      <= adv1 && (addr_s1 == in_col_q);
			byp_data_s1 <= {mid_w, pix_s1};
		end
		if (adv1) ctrl_s2 <= ctrl_s1;
		if (adv2) ctrl_s3 <= ctrl_s2;
		if (adv3) ctrl_s4 <= ctrl_s3;
	end

	icv_ram #(
		.WIDTH (RAM_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (adv1),
		.wr_addr (addr_s1),
		.wr_data ({mid_w, pix_s1}),
		.rd_en   (accept),
		.rd_addr (in_col_q),
		.rd_data (ram_rdata)
	);

	// stages 2 to 4: chain of window column cells
	assign col_in[TAPS-1] = {pix_s1, mid_w, top_w};

	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		if (k < TAPS - 1) begin : g_link
			assign col_in[k] = col_q[k+1];
		end
		for (genvar r = 0; r < TAPS; r++) begin : g_coeff
			assign coeff_k[k][r] = kern_q[r][LANE_BITS*k +: COEFF_BITS];
		end

		icv_cell #(
			.COEFF_BITS (COEFF_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.col_load   (adv1),
			.col_in     (col_in[k]),
			.prod_load  (adv2),
			.row_ok     (ctrl_s2.row_ok),
			.col_ok     (ctrl_s2.col_ok[k]),
			.coeff      (coeff_k[k]),
			.sum_load   (adv3),
			.col_q      (col_q[k]),
			.col_sum_s4 (col_sum[k])
		);
	end

	// stage 5: column sum, truncate, saturate
	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			tot[ch] = SUM_W'($signed(col_sum[0][ch])) + SUM_W'($signed(col_sum[1][ch]))
				+ SUM_W'($signed(col_sum[2][ch]));
			if (ch >= int'(chans) || tot[ch][SUM_W-1] || tot[ch] == '0) begin
				res_word[PIX_BITS*ch +: PIX_BITS] = '0;
			end else if (|tot[ch][SUM_W-2:FRAC_BITS+PIX_BITS]) begin
				res_word[PIX_BITS*ch +: PIX_BITS] = '1;
			end else begin
				res_word[PIX_BITS*ch +: PIX_BITS] = tot[ch][FRAC_BITS+PIX_BITS-1:FRAC_BITS];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv4 && ctrl_s4.emit) begin
			out_data_q <= res_word;
			out_last_q <= ctrl_s4.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && acc_ctrl.emit && acc_ctrl.last) |=>
		(in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0))
		else $error("position counters not cleared after frame end");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_axis_tready)
		else $error("input stalled with empty output register");

endmodule
